@@ hdl/serial_bank_mapper_top_defines.svh @@
// Assertion macros shared by the serial bank mapper RTL.
// Expects clk and rst in the scope of the including module.
`ifndef SERIAL_BANK_MAPPER_TOP_DEFINES_SVH
`define SERIAL_BANK_MAPPER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SBM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define SBM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/sbm_pkg.sv @@
// Shared types and codes for the serial bank mapper.
// No dependencies; imported by every mapper module.
`default_nettype none

package sbm_pkg;

  localparam logic [1:0] OP_TICK      = 2'd0;
  localparam logic [1:0] OP_CPU_WRITE = 2'd1;
  localparam logic [1:0] OP_CPU_READ  = 2'd2;
  localparam logic [1:0] OP_PPU_READ  = 2'd3;

  localparam logic [1:0] TGT_NONE  = 2'd0;
  localparam logic [1:0] TGT_WRAM  = 2'd1;
  localparam logic [1:0] TGT_PRG   = 2'd2;
  localparam logic [1:0] TGT_CHR   = 2'd3;

  localparam logic [1:0] SEL_CONTROL  = 2'd0;
  localparam logic [1:0] SEL_CHR_LOW  = 2'd1;
  localparam logic [1:0] SEL_CHR_HIGH = 2'd2;
  localparam logic [1:0] SEL_PRG      = 2'd3;

  localparam logic [1:0] PRG_FIX_FIRST = 2'd2;
  localparam logic [1:0] PRG_FIX_LAST  = 2'd3;

  localparam logic       CFG_PRG_COUNT = 1'b0;
  localparam logic       CFG_CHR_COUNT = 1'b1;

  localparam logic [4:0] SHIFT_MARK    = 5'h10;
  localparam logic [4:0] CONTROL_RESET = 5'h0C;
  localparam logic [4:0] LARGE_MASK    = 5'h0F;
  localparam logic [5:0] PRG_COUNT_RESET = 6'd16;
  localparam logic [4:0] CHR_COUNT_RESET = 5'd1;
  localparam logic [1:0] TICKS_FULL    = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] address;
    logic [7:0]  data;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  target;
    logic [18:0] offset;
    logic [1:0]  mirroring;
    logic        write_taken;
  } rsp_t;

  typedef struct packed {
    logic [4:0] control;
    logic [4:0] chr_low;
    logic [4:0] chr_high;
    logic [4:0] prg_bank;
  } bank_regs_t;

endpackage

`default_nettype wire

@@ hdl/sbm_xlate.sv @@
// Address translation for CPU and PPU lookups.
// Depends on sbm_pkg; purely combinational from the bank registers.
`default_nettype none

module sbm_xlate
  import sbm_pkg::*;
(
  input  var cmd_t       cmd,
  input  var bank_regs_t regs,
  input  wire [5:0]      prg_count,
  input  wire [4:0]      chr_count,
  output logic [1:0]     target,
  output logic [18:0]    offset
);

  logic        outer_mode;
  logic [4:0]  prg_mask;
  logic        outer;
  logic [4:0]  prg_sel;
  logic        upper;
  logic [4:0]  bank16;
  logic [4:0]  prg_hi;
  logic [18:0] prg_offset;
  logic [5:0]  chr_mask;
  logic [5:0]  chr_sel4;
  logic [4:0]  chr_sel8;
  logic [18:0] chr_offset;
  logic [18:0] wram_offset;
  logic        in_wram;

  always_comb begin
    outer_mode = prg_count[5];
    prg_mask   = outer_mode ? LARGE_MASK : (prg_count[4:0] - 5'd1);
    outer      = outer_mode & regs.chr_low[4];
    prg_sel    = regs.prg_bank & prg_mask;
    upper      = cmd.address[14];
    case (regs.control[3:2])
      PRG_FIX_FIRST: bank16 = upper ? prg_sel : 5'd0;
      PRG_FIX_LAST:  bank16 = upper ? prg_mask : prg_sel;
      default:       bank16 = {prg_sel[4:1], upper};
    endcase
    prg_hi     = bank16 + {outer, 4'd0};
    prg_offset = {prg_hi, cmd.address[13:0]};

    chr_mask = (chr_count == 5'd0) ? 6'd1 : ({chr_count, 1'b0} - 6'd1);
    chr_sel4 = (cmd.address[12] ? {1'b0, regs.chr_high} : {1'b0, regs.chr_low}) & chr_mask;
    chr_sel8 = {1'b0, regs.chr_low[4:1]} & (chr_mask[5:1] | 5'd1);
    if (regs.control[4]) begin
      chr_offset = {1'b0, chr_sel4, cmd.address[11:0]};
    end else begin
      chr_offset = {1'b0, chr_sel8, cmd.address[12:0]};
    end

    in_wram     = (cmd.address[15:13] == 3'b011);
    wram_offset = {6'd0, cmd.address[12:0]};

    target = TGT_NONE;
    offset = '0;
    unique case (cmd.operation)
      OP_TICK: begin
      end
      OP_CPU_WRITE: begin
        if (in_wram) begin
          target = TGT_WRAM;
          offset = wram_offset;
        end
      end
      OP_CPU_READ: begin
        if (cmd.address[15]) begin
          target = TGT_PRG;
          offset = prg_offset;
        end else if (in_wram) begin
          target = TGT_WRAM;
          offset = wram_offset;
        end
      end
      OP_PPU_READ: begin
        if (cmd.address[15:13] == 3'b000) begin
          target = TGT_CHR;
          offset = chr_offset;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/sbm_load.sv @@
// Serial register loader: tick filter, shift register and bank registers.
// Depends on sbm_pkg; state advances once per transfer out of the input stage.
`default_nettype none

module sbm_load
  import sbm_pkg::*;
(
  input  wire            clk,
  input  wire            rst,
  input  wire            advance,
  input  var cmd_t       cmd,
  output bank_regs_t     regs,
  output logic [1:0]     mirroring,
  output logic           write_taken
);

  logic [4:0] shift;
  logic [4:0] shift_next;
  logic [1:0] ticks;
  logic [1:0] ticks_next;
  bank_regs_t regs_next;
  logic [4:0] load_val;

  always_comb begin
    shift_next  = shift;
    ticks_next  = ticks;
    regs_next   = regs;
    write_taken = 1'b0;
    load_val    = {cmd.data[0], shift[4:1]};
    if (cmd.operation == OP_TICK) begin
      if (ticks != TICKS_FULL) begin
        ticks_next = ticks + 2'd1;
      end
    end else if (cmd.operation == OP_CPU_WRITE && cmd.address[15]) begin
      ticks_next = 2'd0;
      if (ticks == TICKS_FULL) begin
        write_taken = 1'b1;
        if (cmd.data[7]) begin
          shift_next           = SHIFT_MARK;
          regs_next.control[3:2] = 2'b11;
        end else if (shift[0]) begin
          shift_next = SHIFT_MARK;
          unique case (cmd.address[14:13])
            SEL_CONTROL:  regs_next.control  = load_val;
            SEL_CHR_LOW:  regs_next.chr_low  = load_val;
            SEL_CHR_HIGH: regs_next.chr_high = load_val;
            SEL_PRG:      regs_next.prg_bank = load_val;
            default:      regs_next.prg_bank = load_val;
          endcase
        end else begin
          shift_next = load_val;
        end
      end
    end
    mirroring = regs_next.control[1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift <= SHIFT_MARK;
      ticks <= 2'd0;
      regs  <= '{control: CONTROL_RESET, chr_low: 5'd0, chr_high: 5'd0, prg_bank: 5'd0};
    end else if (advance) begin
      shift <= shift_next;
      ticks <= ticks_next;
      regs  <= regs_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/serial_bank_mapper_top.sv @@
// Serial bank mapper top level: input stage, loader, translator, result register.
// Depends on sbm_pkg, sbm_load, sbm_xlate and the shared assertion macros.
//
// Usage:
//   cmd channel (cmd_valid, cmd_stall, cmd) carries one tick, CPU write, CPU
//   lookup or PPU pattern lookup per transfer. rsp channel (rsp_valid,
//   rsp_stall, rsp) returns exactly one result per command, in order.
//   A transfer happens on a rising edge with valid high and stall low.
//   Path: a transferred command is held in the input register, its result is
//   then loaded into the result register and transfers from there.
//   Throughput: one command per cycle while the result register is not stalled,
//   set by the single pass through loader and translator.
//   When rsp_stall is high the result register holds and the input stage
//   keeps one command; cmd_stall rises once the input stage is full.
//   cfg_we writes prg_count (index 0) or chr_count (index 1);
//   write only while no command is in flight.
//   Synchronous reset empties both stages, restores the bank counts to
//   16 and 1, the control register to 0x0C, the shift register to its
//   marker and clears the other bank registers and the tick filter.
`default_nettype none
`include "serial_bank_mapper_top_defines.svh"

module serial_bank_mapper_top
  import sbm_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        cmd_valid,
  output logic       cmd_stall,
  input  var cmd_t   cmd,
  output logic       rsp_valid,
  input  wire        rsp_stall,
  output rsp_t       rsp,
  input  wire        cfg_we,
  input  wire        cfg_index,
  input  wire [5:0]  cfg_data
);

  logic       stage_valid;
  logic       stage_valid_next;
  cmd_t       stage;
  logic       stage_adv;
  logic       cmd_take;
  logic       rsp_valid_next;
  logic [5:0] prg_count;
  logic [4:0] chr_count;
  bank_regs_t regs;
  logic [1:0] mirroring;
  logic       write_taken;
  logic [1:0] target;
  logic [18:0] offset;

  assign stage_adv        = stage_valid && (!rsp_valid || !rsp_stall);
  assign cmd_stall        = stage_valid && !stage_adv;
  assign cmd_take         = cmd_valid && !cmd_stall;
  assign stage_valid_next = cmd_take || (stage_valid && !stage_adv);
  assign rsp_valid_next   = stage_adv || (rsp_valid && rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      stage_valid <= stage_valid_next;
      rsp_valid   <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      stage <= cmd;
    end
    if (stage_adv) begin
      rsp <= '{target: target, offset: offset, mirroring: mirroring,
               write_taken: write_taken};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_count <= PRG_COUNT_RESET;
      chr_count <= CHR_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRG_COUNT: prg_count <= cfg_data;
        CFG_CHR_COUNT: chr_count <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  sbm_load u_load (
    .clk         (clk),
    .rst         (rst),
    .advance     (stage_adv),
    .cmd         (stage),
    .regs        (regs),
    .mirroring   (mirroring),
    .write_taken (write_taken)
  );

  sbm_xlate u_xlate (
    .cmd       (stage),
    .regs      (regs),
    .prg_count (prg_count),
    .chr_count (chr_count),
    .target    (target),
    .offset    (offset)
  );

  `SBM_ASSERT_NOW(a_taken_no_target, rsp_valid && rsp.write_taken, rsp.target == TGT_NONE)
  `SBM_ASSERT_NOW(a_none_zero_offset, rsp_valid && rsp.target == TGT_NONE, rsp.offset == 19'd0)
  `SBM_ASSERT_NEXT(a_stage_hold, stage_valid && !stage_adv, stage_valid && $stable(stage))
  `SBM_ASSERT_NOW(a_empty_no_stall, !stage_valid, !cmd_stall)

endmodule

`default_nettype wire

@@ tb/serial_bank_mapper_top_test.sv @@
// Self-checking testbench for serial_bank_mapper_top: directed and random command
// traffic, random gaps on cmd and stalls on rsp, checked by an in-bench predictor.
// Depends on sbm_pkg and the serial_bank_mapper_top RTL.
module serial_bank_mapper_top_test;
  import sbm_pkg::*;

  localparam int SEG_ITEMS   = 230;
  localparam int LONG_HOLD   = 80;
  localparam int CYCLE_LIMIT = 400000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cmd_valid = 1'b0;
  logic       cmd_stall;
  cmd_t       cmd = '0;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  rsp_t       rsp;
  logic       cfg_we = 1'b0;
  logic       cfg_index = 1'b0;
  logic [5:0] cfg_data = '0;

  // predictor state
  logic [4:0] load_shift;
  logic [4:0] ctrl_reg;
  logic [4:0] chr_low_reg;
  logic [4:0] chr_high_reg;
  logic [4:0] prg_reg;
  logic [1:0] tick_count;
  logic [5:0] prg_count;
  logic [4:0] chr_count;

  cmd_t cmd_backlog[$];
  rsp_t awaited_rsp[$];
  rsp_t want_rsp;

  int queued_count = 0;
  int accepted_count = 0;
  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_token = 0;
  int hold_served = 0;
  int hold_left = 0;

  serial_bank_mapper_top u_top (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic rsp_t map_command(cmd_t c);
    rsp_t       r;
    logic       outer_mode;
    logic [4:0] mask;
    logic [4:0] sel;
    logic [4:0] bank;
    logic [4:0] bank4;
    logic [3:0] bank8;
    logic [5:0] chr_mask;
    logic [5:0] half_mask;
    r = '0;
    case (c.operation)
      OP_TICK: begin
        if (tick_count < TICKS_FULL) tick_count = tick_count + 2'd1;
      end
      OP_CPU_WRITE: begin
        if (c.address[15]) begin
          if (tick_count >= TICKS_FULL) begin
            r.write_taken = 1'b1;
            if (c.data[7]) begin
              load_shift = SHIFT_MARK;
              ctrl_reg[3:2] = 2'b11;
            end else if (load_shift[0]) begin
              case (c.address[14:13])
                SEL_CONTROL:  ctrl_reg = {c.data[0], load_shift[4:1]};
                SEL_CHR_LOW:  chr_low_reg = {c.data[0], load_shift[4:1]};
                SEL_CHR_HIGH: chr_high_reg = {c.data[0], load_shift[4:1]};
                default:      prg_reg = {c.data[0], load_shift[4:1]};
              endcase
              load_shift = SHIFT_MARK;
            end else begin
              load_shift = {c.data[0], load_shift[4:1]};
            end
          end
          tick_count = '0;
        end else if (c.address >= 16'h6000) begin
          r.target = TGT_WRAM;
          r.offset = 19'(c.address[12:0]);
        end
      end
      OP_CPU_READ: begin
        if (c.address[15]) begin
          outer_mode = prg_count >= 6'd32;
          mask = outer_mode ? LARGE_MASK : 5'(prg_count - 6'd1);
          sel = prg_reg & mask;
          case (ctrl_reg[3:2])
            PRG_FIX_FIRST: bank = c.address[14] ? sel : 5'd0;
            PRG_FIX_LAST:  bank = c.address[14] ? mask : sel;
            default:       bank = {sel[4:1], c.address[14]};
          endcase
          r.target = TGT_PRG;
          r.offset = {outer_mode & chr_low_reg[4], 18'd0} + {bank, 14'd0}
                     + 19'(c.address[13:0]);
        end else if (c.address >= 16'h6000) begin
          r.target = TGT_WRAM;
          r.offset = 19'(c.address[12:0]);
        end
      end
      default: begin
        if (c.address < 16'h2000) begin
          chr_mask = (chr_count == 5'd0) ? 6'd1 : 6'({chr_count, 1'b0} - 6'd1);
          r.target = TGT_CHR;
          if (ctrl_reg[4]) begin
            bank4 = (c.address[12] ? chr_high_reg : chr_low_reg) & chr_mask[4:0];
            r.offset = 19'({bank4, c.address[11:0]});
          end else begin
            half_mask = (chr_mask >> 1) | 6'd1;
            bank8 = chr_low_reg[4:1] & half_mask[3:0];
            r.offset = 19'({bank8, c.address[12:0]});
          end
        end
      end
    endcase
    r.mirroring = ctrl_reg[1:0];
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // command driver
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        awaited_rsp.push_back(map_command(cmd));
        accepted_count++;
      end
      if (!cmd_valid || !cmd_stall) begin
        if (cmd_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd <= cmd_backlog.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // result stall
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_served != hold_token) begin
      hold_served <= hold_token;
      hold_left <= LONG_HOLD;
      rsp_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (awaited_rsp.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %p", $time, rsp);
        error_count++;
      end else begin
        want_rsp = awaited_rsp.pop_front();
        check_field("target", int'(want_rsp.target), int'(rsp.target));
        check_field("offset", int'(want_rsp.offset), int'(rsp.offset));
        check_field("mirroring", int'(want_rsp.mirroring), int'(rsp.mirroring));
        check_field("write_taken", int'(want_rsp.write_taken), int'(rsp.write_taken));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic queue_cmd(logic [1:0] op, logic [15:0] addr, logic [7:0] dat);
    cmd_backlog.push_back(cmd_t'({op, addr, dat}));
    queued_count++;
  endtask

  task automatic queue_ticks(int count);
    repeat (count) queue_cmd(OP_TICK, 16'($urandom), 8'($urandom));
  endtask

  task automatic queue_lookup();
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) queue_cmd(OP_CPU_READ, 16'($urandom_range(16'h8000, 16'hFFFF)), 8'($urandom));
    else if (pick < 85) queue_cmd(OP_PPU_READ, 16'($urandom_range(0, 16'h1FFF)), 8'($urandom));
    else if (pick < 93) queue_cmd(OP_CPU_READ, 16'($urandom), 8'($urandom));
    else queue_cmd(OP_CPU_WRITE, 16'($urandom_range(16'h6000, 16'h7FFF)), 8'($urandom));
  endtask

  // five serial writes; now and then one tick short so the filter drops a bit
  task automatic queue_load(logic [1:0] sel, logic [4:0] value);
    for (int b = 0; b < 5; b++) begin
      queue_ticks(($urandom_range(9) == 0) ? 1 : 2 + $urandom_range(1));
      if ($urandom_range(3) == 0) queue_lookup();
      queue_cmd(OP_CPU_WRITE, {1'b1, sel, 13'($urandom)}, {1'b0, 6'($urandom), value[b]});
    end
  endtask

  task automatic queue_activity();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      queue_load(2'($urandom), 5'($urandom));
    end else if (pick < 50) begin
      queue_ticks(2);
      queue_cmd(OP_CPU_WRITE, 16'($urandom_range(16'h8000, 16'hFFFF)),
                {1'b1, 7'($urandom)});
    end else if (pick < 85) begin
      queue_lookup();
    end else begin
      queue_cmd(2'($urandom), 16'($urandom), 8'($urandom));
    end
  endtask

  task automatic write_cfg(logic idx, logic [5:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_PRG_COUNT) prg_count = val;
    else chr_count = val[4:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_sizes(logic [5:0] prg, logic [4:0] chr);
    write_cfg(CFG_PRG_COUNT, prg);
    write_cfg(CFG_CHR_COUNT, {1'b0, chr});
  endtask

  task automatic wait_idle();
    while (cmd_backlog.size() != 0 || cmd_valid || awaited_rsp.size() != 0) @(negedge clk);
  endtask

  initial begin
    int goal;
    int mark;
    load_shift = SHIFT_MARK;
    ctrl_reg = CONTROL_RESET;
    chr_low_reg = '0;
    chr_high_reg = '0;
    prg_reg = '0;
    tick_count = '0;
    prg_count = PRG_COUNT_RESET;
    chr_count = CHR_COUNT_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 25;
    recv_idle_pct = 48;
    queue_cmd(OP_TICK, 16'hFFFF, 8'hFF);
    queue_cmd(OP_CPU_WRITE, 16'h8000, 8'h01);
    queue_cmd(OP_CPU_WRITE, 16'h6000, 8'h00);
    queue_cmd(OP_CPU_WRITE, 16'h7FFF, 8'hFF);
    queue_cmd(OP_CPU_WRITE, 16'h5FFF, 8'h55);
    queue_cmd(OP_CPU_READ, 16'h0000, 8'h00);
    queue_cmd(OP_CPU_READ, 16'h6000, 8'h00);
    queue_cmd(OP_CPU_READ, 16'h8000, 8'h00);
    queue_cmd(OP_CPU_READ, 16'hC000, 8'h00);
    queue_cmd(OP_CPU_READ, 16'hFFFF, 8'hFF);
    queue_cmd(OP_PPU_READ, 16'h0000, 8'h00);
    queue_cmd(OP_PPU_READ, 16'h1000, 8'h00);
    queue_cmd(OP_PPU_READ, 16'h1FFF, 8'h00);
    queue_cmd(OP_PPU_READ, 16'h2000, 8'h00);
    queue_cmd(OP_PPU_READ, 16'hFFFF, 8'hFF);
    queue_ticks(3);
    queue_cmd(OP_CPU_WRITE, 16'hFFFF, 8'hFF);
    queue_cmd(OP_CPU_READ, 16'hFFFF, 8'h00);

    for (int seg = 0; seg < 8; seg++) begin
      case (seg)
        1: set_sizes(6'd32, 5'd0);
        2: set_sizes(6'd1, 5'd16);
        3: set_sizes(6'd63, 5'd31);
        4: set_sizes(6'd0, 5'd2);
        5: set_sizes(6'd8, 5'd4);
        6: set_sizes(6'd2, 5'd8);
        7: set_sizes(6'($urandom_range(63)), 5'($urandom_range(31)));
        default: ;
      endcase
      send_idle_pct = (seg < 3) ? 25 : (seg < 6) ? 48 : 0;
      recv_idle_pct = (seg < 3) ? 48 : (seg < 6) ? 25 : 0;
      goal = queued_count + SEG_ITEMS;
      while (queued_count < goal) queue_activity();
      if (seg == 1 || seg == 6) begin
        mark = accepted_count + 20;
        while (accepted_count < mark) @(negedge clk);
        hold_token++;
      end
      wait_idle();
    end

    repeat (8) @(negedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
